// ===== design/tsb_pkg.sv =====
// ----------------------------------------------------------------------------
// tsb_pkg
// Shared sizes, codes and types of the timestamp sorted buffer.
// ----------------------------------------------------------------------------
package tsb_pkg;

	localparam int DEPTH         = 16;
	localparam int STREAMS       = 4;
	localparam int STAMP_WIDTH   = 32;
	localparam int PAYLOAD_WIDTH = 64;

	// Fixed field widths of the channels
	localparam int OP_W      = 2;
	localparam int STREAM_W  = 2;
	localparam int FSTAMP_W  = 32;
	localparam int FPAY_W    = 64;
	localparam int STATUS_W  = 2;

	localparam int CNT_W = $clog2(DEPTH + 1);

	localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
	localparam logic [OP_W-1:0] OP_QUERY  = 2'd1;
	localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

	localparam logic [STATUS_W-1:0] ST_STORED    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_EVICTED   = 2'd1;
	localparam logic [STATUS_W-1:0] ST_DUPLICATE = 2'd2;
	localparam logic [STATUS_W-1:0] ST_DROPPED   = 2'd3;

	typedef logic [STAMP_WIDTH-1:0]   stamp_t;
	typedef logic [PAYLOAD_WIDTH-1:0] payload_t;
	typedef logic [CNT_W-1:0]         count_t;

	// Per-row command for the cells
	typedef struct packed {
		logic cmp;    // capture compare flags against the incoming stamp
		logic grow;   // insert into a store with room, shift upper part up
		logic evict;  // insert into a full store, shift lower part down
		logic clear;  // empty the store
	} row_ctrl_t;

	// Per-row summary of the captured compare flags
	typedef struct packed {
		logic dup;    // some held stamp equals the new one
		logic full;   // store holds DEPTH entries
		logic lt0;    // first entry is below the new stamp
	} row_stat_t;

endpackage

// ===== design/tsb_if.sv =====
// ----------------------------------------------------------------------------
// tsb_if
// Command and response channels of the timestamp sorted buffer.
// ----------------------------------------------------------------------------
interface tsb_cmd_if;
	logic                            valid;
	logic                            ready;
	logic [tsb_pkg::OP_W-1:0]        op;
	logic [tsb_pkg::STREAM_W-1:0]    stream;
	logic [tsb_pkg::FSTAMP_W-1:0]    stamp;
	logic [tsb_pkg::FPAY_W-1:0]      payload;

	modport source (output valid, op, stream, stamp, payload, input ready);
	modport sink   (input valid, op, stream, stamp, payload, output ready);
endinterface

interface tsb_rsp_if;
	logic                            valid;
	logic                            ready;
	logic [tsb_pkg::STATUS_W-1:0]    status;
	logic                            found;
	logic [tsb_pkg::FSTAMP_W-1:0]    found_stamp;
	logic [tsb_pkg::FPAY_W-1:0]      found_payload;

	modport source (output valid, status, found, found_stamp, found_payload, input ready);
	modport sink   (input valid, status, found, found_stamp, found_payload, output ready);
endinterface

// ===== design/timestamp_sorted_buffer.sv =====
// ----------------------------------------------------------------------------
// timestamp_sorted_buffer
// Four timestamp-sorted measurement stores with insert, next-after query
// and clear, each store a chain of shifting cells.
// A command is held in the command registers; the shift and the response
// follow once the response slot is free. No new command is taken until the last
// one is applied. Compare flags are captured in all cells on the accept edge.
// A stalled response slot holds the shift and the response until it frees up.
// Reset: arst_n empties every store and the response slot; no clearing pass.
// ----------------------------------------------------------------------------
module timestamp_sorted_buffer (
	input  logic        clk,
	input  logic        arst_n,
	tsb_cmd_if.sink     cmd,
	tsb_rsp_if.source   rsp
);

	logic [tsb_pkg::OP_W-1:0]     op_s1;
	logic [tsb_pkg::STREAM_W-1:0] stream_s1;
	tsb_pkg::stamp_t              stamp_s1;
	tsb_pkg::payload_t            payload_s1;
	logic                         busy_q;

	logic                         rsp_valid_q;
	logic [tsb_pkg::STATUS_W-1:0] status_q;
	logic                         found_q;
	logic [tsb_pkg::FSTAMP_W-1:0] found_stamp_q;
	logic [tsb_pkg::FPAY_W-1:0]   found_payload_q;

	logic accept, apply, row_ok, ins_ok, grow_sel, evict_sel;
	logic [tsb_pkg::STATUS_W-1:0] status_d;

	tsb_pkg::row_ctrl_t  ctrl   [tsb_pkg::STREAMS];
	tsb_pkg::row_stat_t  stat   [tsb_pkg::STREAMS];
	logic                fnd    [tsb_pkg::STREAMS];
	tsb_pkg::stamp_t     hstamp [tsb_pkg::STREAMS];
	tsb_pkg::payload_t   hpay   [tsb_pkg::STREAMS];

	tsb_pkg::row_stat_t  sel_stat;
	logic                sel_found;
	tsb_pkg::stamp_t     sel_stamp;
	tsb_pkg::payload_t   sel_pay;

	assign cmd.ready = !busy_q;
	assign accept    = cmd.valid && cmd.ready;
	assign apply     = busy_q && (!rsp_valid_q || rsp.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (accept) begin
			busy_q <= 1'b1;
		end else if (apply) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1      <= cmd.op;
			stream_s1  <= cmd.stream;
			stamp_s1   <= cmd.stamp[tsb_pkg::STAMP_WIDTH-1:0];
			payload_s1 <= cmd.payload[tsb_pkg::PAYLOAD_WIDTH-1:0];
		end
	end

	assign row_ok = int'(stream_s1) < tsb_pkg::STREAMS;

	always_comb begin
		sel_stat  = '0;
		sel_found = 1'b0;
		sel_stamp = '0;
		sel_pay   = '0;
		for (int r = 0; r < tsb_pkg::STREAMS; r++) begin
			if (tsb_pkg::STREAM_W'(r) == stream_s1) begin
				sel_stat  = stat[r];
				sel_found = fnd[r];
				sel_stamp = hstamp[r];
				sel_pay   = hpay[r];
			end
		end
	end

	assign ins_ok    = (op_s1 == tsb_pkg::OP_INSERT) && row_ok && !sel_stat.dup;
	assign grow_sel  = ins_ok && !sel_stat.full;
	assign evict_sel = ins_ok && sel_stat.full && sel_stat.lt0;

	for (genvar r = 0; r < tsb_pkg::STREAMS; r++) begin : g_row
		logic hit_row;
		assign hit_row = apply && (stream_s1 == tsb_pkg::STREAM_W'(r));

		assign ctrl[r].cmp   = accept;
		assign ctrl[r].grow  = hit_row && grow_sel;
		assign ctrl[r].evict = hit_row && evict_sel;
		assign ctrl[r].clear = apply && (op_s1 == tsb_pkg::OP_CLEAR);

		tsb_row u_row (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctrl        (ctrl[r]),
			.cmp_stamp   (cmd.stamp[tsb_pkg::STAMP_WIDTH-1:0]),
			.new_stamp   (stamp_s1),
			.new_payload (payload_s1),
			.stat        (stat[r]),
			.found       (fnd[r]),
			.hit_stamp   (hstamp[r]),
			.hit_payload (hpay[r])
		);
	end

	always_comb begin
		if (!row_ok) begin
			status_d = tsb_pkg::ST_DROPPED;
		end else if (sel_stat.dup) begin
			status_d = tsb_pkg::ST_DUPLICATE;
		end else if (!sel_stat.full) begin
			status_d = tsb_pkg::ST_STORED;
		end else if (sel_stat.lt0) begin
			status_d = tsb_pkg::ST_EVICTED;
		end else begin
			status_d = tsb_pkg::ST_DROPPED;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (apply) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (apply) begin
			status_q        <= '0;
			found_q         <= 1'b0;
			found_stamp_q   <= '0;
			found_payload_q <= '0;
			unique case (op_s1)
				tsb_pkg::OP_INSERT: begin
					status_q <= status_d;
				end
				tsb_pkg::OP_QUERY: begin
					if (row_ok && sel_found) begin
						found_q         <= 1'b1;
						found_stamp_q   <= tsb_pkg::FSTAMP_W'(sel_stamp);
						found_payload_q <= tsb_pkg::FPAY_W'(sel_pay);
					end
				end
				default: begin
					// clear and unused op: all-zero response
				end
			endcase
		end
	end

	assign rsp.valid         = rsp_valid_q;
	assign rsp.status        = status_q;
	assign rsp.found         = found_q;
	assign rsp.found_stamp   = found_stamp_q;
	assign rsp.found_payload = found_payload_q;

endmodule

// ===== design/tsb_cell.sv =====
// ----------------------------------------------------------------------------
// tsb_cell
// One slot of a sorted store: holds a stamp and payload, captures compare
// flags and takes data from itself, a neighbor or the new entry.
// ----------------------------------------------------------------------------
module tsb_cell (
	input  logic                clk,
	input  tsb_pkg::row_ctrl_t  ctrl,
	input  logic                occ,
	input  tsb_pkg::stamp_t     cmp_stamp,
	input  tsb_pkg::stamp_t     new_stamp,
	input  tsb_pkg::payload_t   new_payload,
	input  tsb_pkg::stamp_t     left_stamp,
	input  tsb_pkg::payload_t   left_payload,
	input  logic                left_lt,
	input  tsb_pkg::stamp_t     right_stamp,
	input  tsb_pkg::payload_t   right_payload,
	input  logic                right_lt,
	output tsb_pkg::stamp_t     stamp_q,
	output tsb_pkg::payload_t   payload_q,
	output logic                lt_q,
	output logic                eq_q,
	output logic                gt_q
);

	always_ff @(posedge clk) begin
		if (ctrl.cmp) begin
			lt_q <= occ && (stamp_q < cmp_stamp);
			eq_q <= occ && (stamp_q == cmp_stamp);
			gt_q <= occ && (stamp_q > cmp_stamp);
		end
		if (ctrl.grow) begin
			// below the insert point: hold; at it: take new; above: take left
			if (!lt_q) begin
				if (left_lt) begin
					stamp_q   <= new_stamp;
					payload_q <= new_payload;
				end else begin
					stamp_q   <= left_stamp;
					payload_q <= left_payload;
				end
			end
		end else if (ctrl.evict) begin
			// oldest falls off the bottom; the new entry lands just below pos
			if (right_lt) begin
				stamp_q   <= right_stamp;
				payload_q <= right_payload;
			end else if (lt_q) begin
				stamp_q   <= new_stamp;
				payload_q <= new_payload;
			end
		end
	end

endmodule

// ===== design/tsb_row.sv =====
// ----------------------------------------------------------------------------
// tsb_row
// One store: a chain of DEPTH cells kept sorted ascending, with its fill
// count, insert summary and query hit selection.
// ----------------------------------------------------------------------------
module tsb_row (
	input  logic                clk,
	input  logic                arst_n,
	input  tsb_pkg::row_ctrl_t  ctrl,
	input  tsb_pkg::stamp_t     cmp_stamp,
	input  tsb_pkg::stamp_t     new_stamp,
	input  tsb_pkg::payload_t   new_payload,
	output tsb_pkg::row_stat_t  stat,
	output logic                found,
	output tsb_pkg::stamp_t     hit_stamp,
	output tsb_pkg::payload_t   hit_payload
);

	tsb_pkg::count_t    count_q;
	tsb_pkg::stamp_t    stamps  [tsb_pkg::DEPTH];
	tsb_pkg::payload_t  pays    [tsb_pkg::DEPTH];
	logic [tsb_pkg::DEPTH-1:0] lt, eq, gt;

	for (genvar i = 0; i < tsb_pkg::DEPTH; i++) begin : g_cell
		tsb_pkg::stamp_t   l_stamp, r_stamp;
		tsb_pkg::payload_t l_pay, r_pay;
		logic              l_lt, r_lt;

		if (i == 0) begin : g_first
			assign l_stamp = new_stamp;
			assign l_pay   = new_payload;
			assign l_lt    = 1'b1;
		end else begin : g_mid_l
			assign l_stamp = stamps[i-1];
			assign l_pay   = pays[i-1];
			assign l_lt    = lt[i-1];
		end

		if (i == tsb_pkg::DEPTH - 1) begin : g_last
			assign r_stamp = new_stamp;
			assign r_pay   = new_payload;
			assign r_lt    = 1'b0;
		end else begin : g_mid_r
			assign r_stamp = stamps[i+1];
			assign r_pay   = pays[i+1];
			assign r_lt    = lt[i+1];
		end

		tsb_cell u_cell (
			.clk           (clk),
			.ctrl          (ctrl),
			.occ           (tsb_pkg::CNT_W'(i) < count_q),
			.cmp_stamp     (cmp_stamp),
			.new_stamp     (new_stamp),
			.new_payload   (new_payload),
			.left_stamp    (l_stamp),
			.left_payload  (l_pay),
			.left_lt       (l_lt),
			.right_stamp   (r_stamp),
			.right_payload (r_pay),
			.right_lt      (r_lt),
			.stamp_q       (stamps[i]),
			.payload_q     (pays[i]),
			.lt_q          (lt[i]),
			.eq_q          (eq[i]),
			.gt_q          (gt[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (ctrl.clear) begin
			count_q <= '0;
		end else if (ctrl.grow) begin
			count_q <= count_q + tsb_pkg::CNT_W'(1);
		end
	end

	assign stat.dup  = |eq;
	assign stat.full = (count_q == tsb_pkg::CNT_W'(tsb_pkg::DEPTH));
	assign stat.lt0  = lt[0];

	// gt flags are monotonic along the sorted row: the first set one is the hit
	always_comb begin
		hit_stamp   = '0;
		hit_payload = '0;
		for (int i = 0; i < tsb_pkg::DEPTH; i++) begin
			if (gt[i] && (i == 0 || !gt[(i == 0) ? 0 : i-1])) begin
				hit_stamp   = hit_stamp | stamps[i];
				hit_payload = hit_payload | pays[i];
			end
		end
	end

	assign found = |gt;

endmodule

// ===== design/tsb_checker.sv =====
// ----------------------------------------------------------------------------
// tsb_checker
// Port-level checks of the timestamp sorted buffer, bound to the top level.
// ----------------------------------------------------------------------------
module tsb_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           cmd_valid,
	input logic                           cmd_ready,
	input logic                           rsp_valid,
	input logic                           rsp_ready,
	input logic [tsb_pkg::STATUS_W-1:0]   rsp_status,
	input logic                           rsp_found,
	input logic [tsb_pkg::FSTAMP_W-1:0]   rsp_found_stamp,
	input logic [tsb_pkg::FPAY_W-1:0]     rsp_found_payload
);

	// a stalled response holds its contents
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
			&& $stable(rsp_found) && $stable(rsp_found_stamp)
			&& $stable(rsp_found_payload))
		else $error("response changed while stalled");

	// one command in work at a time
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready |=> !cmd_ready)
		else $error("command taken while another is in work");

	// a new response only appears after a command was in work
	a_rsp_after_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(!cmd_ready))
		else $error("response without a command");

	// not found carries zero data
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_found |-> rsp_found_stamp == '0 && rsp_found_payload == '0)
		else $error("miss response carries data");

	// insert status and query result never show together
	a_status_excl: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status != tsb_pkg::ST_STORED |-> !rsp_found)
		else $error("status and found both set");

endmodule

bind timestamp_sorted_buffer tsb_checker u_tsb_checker (
	.clk               (clk),
	.arst_n            (arst_n),
	.cmd_valid         (cmd.valid),
	.cmd_ready         (cmd.ready),
	.rsp_valid         (rsp.valid),
	.rsp_ready         (rsp.ready),
	.rsp_status        (rsp.status),
	.rsp_found         (rsp.found),
	.rsp_found_stamp   (rsp.found_stamp),
	.rsp_found_payload (rsp.found_payload)
);
